>>> design/alc_pkg.sv
// ============================================================================
// alc_pkg
// Shared types and constants for the approximate limit counter.
// ============================================================================
package alc_pkg;

    // Default number of client slots and count width.
    localparam int ALC_SLOTS       = 64;
    localparam int ALC_COUNT_WIDTH = 32;

    // Fixed port widths.
    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 6;
    localparam int DATA_W   = 32;

    // Width wide enough to compare a slot number against a slot count of up to 511.
    localparam int SLOT_CMP_W = 9;

    // Reset value of the limit register.
    localparam logic [DATA_W-1:0] LIMIT_RESET = 32'd100000;

    // Request codes.
    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD     = 2'd0,
        ACT_SUB     = 2'd1,
        ACT_READ    = 2'd2,
        ACT_RELEASE = 2'd3
    } t_action;

endpackage

>>> design/alc_ram.sv
// ============================================================================
// alc_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module alc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/alc_div.sv
// ============================================================================
// alc_div
// Division by a constant with a registered quotient; it accepts a new dividend on every start.
// ============================================================================
module alc_div #(
    parameter int WIDTH   = 32,
    parameter int DIVISOR = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient
);

    localparam int SH   = $clog2(DIVISOR);
    localparam int PW   = WIDTH + SH + 1;
    localparam bit POW2 = (DIVISOR == (1 << SH));

    // Reciprocal of the divisor, rounded up: ceil(2^(WIDTH+SH) / DIVISOR).
    // It fits in WIDTH + 1 bits and gives the exact quotient for every
    // dividend of WIDTH bits.
    localparam logic [PW-1:0] SCALE = PW'(1) << (WIDTH + SH);
    localparam logic [PW-1:0] MAGIC = (SCALE + PW'(DIVISOR - 1)) / PW'(DIVISOR);

    logic [WIDTH-1:0] r_q;
    logic             r_done;
    logic [WIDTH-1:0] w_quot;

    if (POW2) begin : g_shift
        assign w_quot = i_dividend >> SH;
    end else begin : g_recip
        logic [2*WIDTH:0] w_prod;
        assign w_prod = (2*WIDTH+1)'(i_dividend) * (2*WIDTH+1)'(MAGIC[WIDTH:0]);
        assign w_quot = WIDTH'(w_prod >> (WIDTH + SH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= w_quot;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

>>> design/approximate_limit_counter.sv
// ============================================================================
// approximate_limit_counter
// Per-slot local counts and allowances in front of a global count and
// reserve, all bounded by a programmable limit.
// ============================================================================
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  ------------------------------------
//  request   i_start & !o_busy            i_action, i_slot, i_amount
//  result    o_done (one-cycle strobe)    o_ok, o_total
//  config    i_cfg_valid & o_cfg_ready    i_cfg_data (count limit)
//
// One request is in flight at a time; o_busy is high from the cycle after a
// request transaction until its result strobe. Reads, releases, fast-path
// adds and subtracts and requests on an absent slot go IDLE -> LOOK -> IDLE.
// A slow-path add or subtract goes on through SPARE and CHECK, and ends
// there when the global room check fails; otherwise it goes on through the
// division of the spare room by SLOTS in DIV and the rebalance write in REBAL.
// Reset is synchronous, and the per-slot valid bits make every slot read as
// zero, so no clearing pass is needed. The result receiver cannot stall, and
// the config port is always ready.
//
module approximate_limit_counter
    import alc_pkg::*;
#(
    parameter int SLOTS       = ALC_SLOTS,
    parameter int COUNT_WIDTH = ALC_COUNT_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_start,
    output logic                o_busy,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [DATA_W-1:0]   i_amount,

    output logic                o_done,
    output logic                o_ok,
    output logic [DATA_W-1:0]   o_total,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [DATA_W-1:0]   i_cfg_data
);

    localparam int CW = COUNT_WIDTH;
    localparam int AW = $clog2(SLOTS);

    // Sequencer states. Fast requests go IDLE -> LOOK -> IDLE; slow-path
    // add and subtract walk through the fold, room check, divide and
    // rebalance states.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOOK  = 6'b000010,
        S_SPARE = 6'b000100,
        S_CHECK = 6'b001000,
        S_DIV   = 6'b010000,
        S_REBAL = 6'b100000
    } t_state;

    t_state            r_state, n_state;

    // Request held for the duration of the transaction.
    t_action           r_action;
    logic [AW-1:0]     r_addr;
    logic              r_slot_ok;
    logic [CW-1:0]     r_amt;

    // Global state and the running sum of every local count, which makes a
    // read a single add instead of a sweep over the slot memory.
    logic [CW-1:0]     r_gc, n_gc;
    logic [CW-1:0]     r_gr, n_gr;
    logic [CW-1:0]     r_lsum, n_lsum;
    logic [CW-1:0]     r_spare;
    logic [DATA_W-1:0] r_limit;

    // One valid bit per slot: a slot never written reads as zero.
    logic              r_vld [SLOTS];

    // Result register.
    logic              r_done, n_done;
    logic              r_ok, n_ok;
    logic [DATA_W-1:0] r_total, n_total;

    // Slot memory: {allowance, count} per slot.
    logic              w_we;
    logic [2*CW-1:0]   w_wdata;
    logic [2*CW-1:0]   w_rdata;
    logic [AW-1:0]     w_raddr;

    logic [SLOT_CMP_W-1:0] w_slot_x;
    logic              w_accept;
    logic [CW-1:0]     w_lc, w_la;
    logic [CW-1:0]     w_limit;

    logic              w_div_start;
    logic [CW-1:0]     w_div_in;
    logic              w_div_done;
    logic [CW-1:0]     w_quot;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_slot_x = SLOT_CMP_W'(i_slot);
    assign w_raddr  = w_slot_x[AW-1:0];
    assign w_limit  = CW'(r_limit);

    // The memory read issued on the request edge is valid in LOOK.
    assign w_lc = r_vld[r_addr] ? w_rdata[CW-1:0]    : '0;
    assign w_la = r_vld[r_addr] ? w_rdata[2*CW-1:CW] : '0;

    alc_ram #(
        .WIDTH (2*CW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    alc_div #(
        .WIDTH   (CW),
        .DIVISOR (SLOTS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_in),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // Next-state and datapath logic for the sequencer.
    always_comb begin
        logic [CW-1:0] share;
        logic [CW-1:0] half;

        n_state     = r_state;
        n_gc        = r_gc;
        n_gr        = r_gr;
        n_lsum      = r_lsum;
        n_done      = 1'b0;
        n_ok        = 1'b1;
        n_total     = '0;
        w_we        = 1'b0;
        w_wdata     = '0;
        w_div_start = 1'b0;
        w_div_in    = '0;
        share       = (w_quot == '0) ? CW'(1) : w_quot;
        half        = (share >> 1) > r_gc ? r_gc : (share >> 1);

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOOK;
                end
            end

            S_LOOK: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                case (r_action) inside
                    ACT_ADD, ACT_SUB: begin
                        if (!r_slot_ok) begin
                            n_ok = 1'b0;
                        end else if ((r_action == ACT_ADD) && ((w_la - w_lc) >= r_amt)) begin
                            // Fast path: room left in the local allowance.
                            w_we    = 1'b1;
                            w_wdata = {w_la, w_lc + r_amt};
                            n_lsum  = r_lsum + r_amt;
                        end else if ((r_action == ACT_SUB) && (w_lc >= r_amt)) begin
                            w_we    = 1'b1;
                            w_wdata = {w_la, w_lc - r_amt};
                            n_lsum  = r_lsum - r_amt;
                        end else begin
                            // Fold the slot back into the global totals.
                            w_we    = 1'b1;
                            n_gc    = r_gc + w_lc;
                            n_gr    = r_gr - w_la;
                            n_lsum  = r_lsum - w_lc;
                            n_done  = 1'b0;
                            n_state = S_SPARE;
                        end
                    end
                    ACT_READ: begin
                        n_total = DATA_W'(r_gc + r_lsum);
                    end
                    default: begin
                        if (r_slot_ok) begin
                            w_we   = 1'b1;
                            n_gc   = r_gc + w_lc;
                            n_gr   = r_gr - w_la;
                            n_lsum = r_lsum - w_lc;
                        end
                    end
                endcase
            end

            S_SPARE: begin
                n_state = S_CHECK;
            end

            S_CHECK: begin
                // The spare room after applying the change follows from the
                // room before it, so the divider can start right away.
                if (r_action == ACT_ADD) begin
                    if (r_spare < r_amt) begin
                        n_ok    = 1'b0;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_gc        = r_gc + r_amt;
                        w_div_in    = r_spare - r_amt;
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end else begin
                    if (r_gc < r_amt) begin
                        n_ok    = 1'b0;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_gc        = r_gc - r_amt;
                        w_div_in    = r_spare + r_amt;
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end

            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_REBAL;
                end
            end

            S_REBAL: begin
                // New allowance is the per-slot share of the spare room, at
                // least one; the slot starts with half of it, or the whole global count if
                // that is smaller, taken from the global count.
                w_we    = 1'b1;
                w_wdata = {share, half};
                n_gr    = r_gr + share;
                n_gc    = r_gc - half;
                n_lsum  = r_lsum + half;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and global state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gc    <= '0;
            r_gr    <= '0;
            r_lsum  <= '0;
            r_limit <= LIMIT_RESET;
            r_done  <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_gc    <= n_gc;
            r_gr    <= n_gr;
            r_lsum  <= n_lsum;
            r_done  <= n_done;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (w_we) begin
                r_vld[r_addr] <= 1'b1;
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action  <= t_action'(i_action);
            r_addr    <= w_raddr;
            r_slot_ok <= (w_slot_x < SLOT_CMP_W'(SLOTS));
            r_amt     <= CW'(i_amount);
        end
        if (r_state == S_SPARE) begin
            r_spare <= w_limit - r_gc - r_gr;
        end
        r_ok    <= n_ok;
        r_total <= n_total;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_ok        = r_ok;
    assign o_total     = r_total;
    assign o_cfg_ready = 1'b1;

endmodule
